/* sv/vpa_pkg.sv */
// ----------------------------------------------------------------------------
// vpa_pkg
// Shared types, codes and defaults for the variable partition allocator.
// ----------------------------------------------------------------------------
package vpa_pkg;

  localparam int unsigned POOL_UNITS_DEF = 1000;
  localparam int unsigned MAX_PARTS_DEF  = 32;

  localparam logic [2:0] STATUS_OK      = 3'd0;
  localparam logic [2:0] STATUS_NOFIT   = 3'd1;
  localparam logic [2:0] STATUS_FULL    = 3'd2;
  localparam logic [2:0] STATUS_NOOWNER = 3'd3;
  localparam logic [2:0] STATUS_ZERO    = 3'd4;

  localparam logic [1:0] FIT_FIRST = 2'd0;
  localparam logic [1:0] FIT_NEXT  = 2'd1;
  localparam logic [1:0] FIT_BEST  = 2'd2;
  localparam logic [1:0] FIT_WORST = 2'd3;

  localparam logic CMD_ALLOC   = 1'b0;
  localparam logic CMD_RECLAIM = 1'b1;

  typedef struct packed {
    logic        command;
    logic [15:0] owner_id;
    logic [15:0] request_size;
  } in_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] granted_base;
    logic [15:0] granted_length;
  } out_t;

  typedef struct packed {
    logic [15:0] base;
    logic [15:0] len;
    logic        used;
    logic [15:0] owner;
    logic [15:0] stamp;
  } part_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_INIT,
    OP_LOAD,
    OP_SCAN,
    OP_PREP_UP,
    OP_SHIFT_UP,
    OP_SPLIT,
    OP_GRANT,
    OP_RD_PREV,
    OP_RD_NEXT,
    OP_CAP_NEXT,
    OP_PREP_DN,
    OP_SHIFT_DN,
    OP_MERGE,
    OP_FAIL
  } op_e;

  typedef enum logic [3:0] {
    S_INIT,
    S_IDLE,
    S_SCAN,
    S_CHECK,
    S_PREP_UP,
    S_SHIFT_UP,
    S_SPLIT,
    S_GRANT,
    S_RD_PREV,
    S_RD_NEXT,
    S_CAP_NEXT,
    S_PREP_DN,
    S_SHIFT_DN,
    S_MERGE,
    S_FAIL
  } state_e;

  typedef struct packed {
    op_e        op;
    logic [2:0] status;
  } ctrl_t;

  typedef struct packed {
    logic scan_done;
    logic up_done;
    logic dn_done;
    logic reclaim;
    logic zero_size;
    logic found;
    logic split;
    logic full;
    logic merge_any;
    logic out_free;
  } stat_t;

endpackage

/* sv/vpa_datapath.sv */
// ----------------------------------------------------------------------------
// vpa_datapath
// Partition table memory, scan and pick registers, shift engine and result
// register of the variable partition allocator.
// ----------------------------------------------------------------------------
module vpa_datapath #(
  parameter int unsigned POOL_UNITS = vpa_pkg::POOL_UNITS_DEF,
  parameter int unsigned MAX_PARTS  = vpa_pkg::MAX_PARTS_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cfg_we_i,
  input  logic [1:0]     cfg_wdata_i,
  input  vpa_pkg::in_t   in_item_i,
  input  vpa_pkg::ctrl_t ctrl_i,
  output vpa_pkg::stat_t stat_o,
  input  logic           out_stall_i,
  output logic           out_valid_o,
  output vpa_pkg::out_t  out_item_o
);
  import vpa_pkg::*;

  localparam int unsigned IW = $clog2(MAX_PARTS);
  localparam int unsigned CW = $clog2(MAX_PARTS + 1);
  localparam logic [CW-1:0] MAXC   = CW'(MAX_PARTS);
  localparam logic [15:0]   POOL16 = 16'(POOL_UNITS);
  localparam logic [16:0]   POOL17 = 17'(POOL_UNITS);

  part_t mem [MAX_PARTS];
  part_t rd_q;
  logic          wr_en, rd_en;
  logic [IW-1:0] wr_addr, rd_addr;
  part_t         wr_data;

  always_ff @(posedge clk_i) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rd_q <= mem[rd_addr];
  end

  logic [CW-1:0] count_q, count_d, idx_q, idx_d;
  logic [15:0]   rover_q, rover_d, stamp_q, stamp_d;
  logic [1:0]    policy_q;
  logic          dv_q, dv_d, found_q, found_d, fa_found_q, fa_found_d;
  logic          prev_free_q, prev_free_d, next_free_q, next_free_d;
  logic          out_valid_q, out_valid_d;

  in_t           item_q, item_d;
  logic [IW-1:0] eidx_q, eidx_d, pick_idx_q, pick_idx_d, fa_idx_q, fa_idx_d;
  logic [15:0]   pick_base_q, pick_base_d, pick_len_q, pick_len_d, pick_age_q, pick_age_d;
  logic [15:0]   fa_base_q, fa_base_d, fa_len_q, fa_len_d;
  logic [15:0]   prev_base_q, prev_base_d, prev_len_q, prev_len_d, next_len_q, next_len_d;
  out_t          out_q, out_d;

  logic [IW-1:0] sel_idx, mrg_idx;
  logic [15:0]   sel_base, sel_len, age, mrg_base, mrg_len;
  logic [CW-1:0] sel1, pick1, idx_m1, rem;
  logic [16:0]   e_end, grant_end;
  logic          fits, after, match, out_free;

  always_comb begin
    if (policy_q == FIT_NEXT && fa_found_q) begin
      sel_idx = fa_idx_q; sel_base = fa_base_q; sel_len = fa_len_q;
    end else begin
      sel_idx = pick_idx_q; sel_base = pick_base_q; sel_len = pick_len_q;
    end
  end

  assign sel1      = CW'(sel_idx) + 1'b1;
  assign pick1     = CW'(pick_idx_q) + 1'b1;
  assign idx_m1    = idx_q - 1'b1;
  assign rem       = CW'(prev_free_q) + CW'(next_free_q);
  assign mrg_idx   = prev_free_q ? pick_idx_q - 1'b1 : pick_idx_q;
  assign mrg_base  = prev_free_q ? prev_base_q : pick_base_q;
  assign mrg_len   = (prev_free_q ? prev_len_q : 16'd0) + pick_len_q
                   + (next_free_q ? next_len_q : 16'd0);
  assign fits      = !rd_q.used && (rd_q.len >= item_q.request_size);
  assign e_end     = {1'b0, rd_q.base} + {1'b0, rd_q.len};
  assign after     = e_end > {1'b0, rover_q};
  assign age       = stamp_q - rd_q.stamp;
  assign match     = rd_q.used && (rd_q.owner == item_q.owner_id);
  assign grant_end = {1'b0, sel_base} + {1'b0, item_q.request_size};
  assign out_free  = !out_valid_q || !out_stall_i;

  always_comb begin
    wr_en = 1'b0; wr_addr = '0; wr_data = '0;
    rd_en = 1'b0; rd_addr = '0;
    count_d = count_q; idx_d = idx_q; rover_d = rover_q; stamp_d = stamp_q;
    dv_d = dv_q; found_d = found_q; fa_found_d = fa_found_q;
    prev_free_d = prev_free_q; next_free_d = next_free_q;
    item_d = item_q; eidx_d = eidx_q;
    pick_idx_d = pick_idx_q; pick_base_d = pick_base_q; pick_len_d = pick_len_q;
    pick_age_d = pick_age_q;
    fa_idx_d = fa_idx_q; fa_base_d = fa_base_q; fa_len_d = fa_len_q;
    prev_base_d = prev_base_q; prev_len_d = prev_len_q; next_len_d = next_len_q;
    out_d = out_q;
    out_valid_d = out_valid_q && out_stall_i;

    case (ctrl_i.op)
      OP_INIT: begin
        wr_en = 1'b1;
        wr_data = '{base: 16'd0, len: POOL16, used: 1'b0, owner: 16'd0, stamp: 16'd0};
      end
      OP_LOAD: begin
        item_d = in_item_i; idx_d = '0; dv_d = 1'b0;
        found_d = 1'b0; fa_found_d = 1'b0;
      end
      OP_SCAN: begin
        if (idx_q < count_q) begin
          rd_en = 1'b1; rd_addr = idx_q[IW-1:0];
          eidx_d = idx_q[IW-1:0]; idx_d = idx_q + 1'b1; dv_d = 1'b1;
        end else begin
          dv_d = 1'b0;
        end
        if (dv_q) begin
          if (item_q.command == CMD_ALLOC) begin
            if (fits) begin
              if ((policy_q == FIT_FIRST && !found_q) || (policy_q == FIT_NEXT && !found_q) ||
                  (policy_q == FIT_BEST && (!found_q || rd_q.len < pick_len_q)) ||
                  (policy_q == FIT_WORST && (!found_q || rd_q.len > pick_len_q))) begin
                found_d = 1'b1; pick_idx_d = eidx_q;
                pick_base_d = rd_q.base; pick_len_d = rd_q.len;
              end
              if (policy_q == FIT_NEXT && after && !fa_found_q) begin
                fa_found_d = 1'b1; fa_idx_d = eidx_q;
                fa_base_d = rd_q.base; fa_len_d = rd_q.len;
              end
            end
          end else if (match && (!found_q || age > pick_age_q)) begin
            found_d = 1'b1; pick_idx_d = eidx_q; pick_age_d = age;
            pick_base_d = rd_q.base; pick_len_d = rd_q.len;
          end
        end
      end
      OP_PREP_UP: begin
        idx_d = count_q; dv_d = 1'b0;
      end
      OP_SHIFT_UP: begin
        if (idx_q > sel1) begin
          rd_en = 1'b1; rd_addr = idx_m1[IW-1:0];
          eidx_d = idx_q[IW-1:0]; idx_d = idx_m1; dv_d = 1'b1;
        end else begin
          dv_d = 1'b0;
        end
        if (dv_q) begin
          wr_en = 1'b1; wr_addr = eidx_q; wr_data = rd_q;
        end
      end
      OP_SPLIT: begin
        wr_en = 1'b1; wr_addr = sel1[IW-1:0];
        wr_data = '{base: sel_base + item_q.request_size,
                    len: sel_len - item_q.request_size,
                    used: 1'b0, owner: 16'd0, stamp: 16'd0};
        count_d = count_q + 1'b1;
      end
      OP_GRANT: begin
        wr_en = 1'b1; wr_addr = sel_idx;
        wr_data = '{base: sel_base, len: item_q.request_size, used: 1'b1,
                    owner: item_q.owner_id, stamp: stamp_q};
        stamp_d = stamp_q + 16'd1;
        rover_d = (grant_end >= POOL17) ? 16'd0 : grant_end[15:0];
        out_valid_d = 1'b1;
        out_d = '{status: STATUS_OK, granted_base: sel_base,
                  granted_length: item_q.request_size};
      end
      OP_RD_PREV: begin
        rd_en = 1'b1; rd_addr = pick_idx_q - 1'b1;
      end
      OP_RD_NEXT: begin
        prev_free_d = (pick_idx_q != '0) && !rd_q.used;
        prev_base_d = rd_q.base; prev_len_d = rd_q.len;
        rd_en = 1'b1; rd_addr = pick_idx_q + 1'b1;
      end
      OP_CAP_NEXT: begin
        next_free_d = (pick1 < count_q) && !rd_q.used;
        next_len_d = rd_q.len;
      end
      OP_PREP_DN: begin
        idx_d = pick1 + CW'(next_free_q); dv_d = 1'b0;
      end
      OP_SHIFT_DN: begin
        if (idx_q < count_q) begin
          rd_en = 1'b1; rd_addr = idx_q[IW-1:0];
          eidx_d = IW'(idx_q - rem); idx_d = idx_q + 1'b1; dv_d = 1'b1;
        end else begin
          dv_d = 1'b0;
        end
        if (dv_q) begin
          wr_en = 1'b1; wr_addr = eidx_q; wr_data = rd_q;
        end
      end
      OP_MERGE: begin
        wr_en = 1'b1; wr_addr = mrg_idx;
        wr_data = '{base: mrg_base, len: mrg_len, used: 1'b0, owner: 16'd0, stamp: 16'd0};
        count_d = count_q - rem;
        out_valid_d = 1'b1;
        out_d = '{status: STATUS_OK, granted_base: pick_base_q, granted_length: pick_len_q};
      end
      OP_FAIL: begin
        out_valid_d = 1'b1;
        out_d = '{status: ctrl_i.status, granted_base: 16'd0, granted_length: 16'd0};
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= CW'(1); idx_q <= '0; rover_q <= '0; stamp_q <= '0; policy_q <= FIT_FIRST;
      dv_q <= 1'b0; found_q <= 1'b0; fa_found_q <= 1'b0;
      prev_free_q <= 1'b0; next_free_q <= 1'b0; out_valid_q <= 1'b0;
    end else begin
      count_q <= count_d; idx_q <= idx_d; rover_q <= rover_d; stamp_q <= stamp_d;
      if (cfg_we_i) policy_q <= cfg_wdata_i;
      dv_q <= dv_d; found_q <= found_d; fa_found_q <= fa_found_d;
      prev_free_q <= prev_free_d; next_free_q <= next_free_d; out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d; eidx_q <= eidx_d;
    pick_idx_q <= pick_idx_d; pick_base_q <= pick_base_d; pick_len_q <= pick_len_d;
    pick_age_q <= pick_age_d;
    fa_idx_q <= fa_idx_d; fa_base_q <= fa_base_d; fa_len_q <= fa_len_d;
    prev_base_q <= prev_base_d; prev_len_q <= prev_len_d; next_len_q <= next_len_d;
    out_q <= out_d;
  end

  assign stat_o = '{
    scan_done: (idx_q >= count_q) && !dv_q,
    up_done:   !(idx_q > sel1) && !dv_q,
    dn_done:   (idx_q >= count_q) && !dv_q,
    reclaim:   item_q.command == CMD_RECLAIM,
    zero_size: item_q.request_size == 16'd0,
    found:     found_q,
    split:     sel_len > item_q.request_size,
    full:      count_q >= MAXC,
    merge_any: prev_free_q || next_free_q,
    out_free:  out_free
  };

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q != '0 && count_q <= MAXC) else $error("partition count out of range");
  a_wr_in_table: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |-> CW'(wr_addr) <= count_q) else $error("write beyond table end");
  a_rover_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rover_q < POOL16 || rover_q == 16'd0) else $error("rover beyond pool");
  a_fa_implies: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fa_found_q |-> found_q) else $error("rover pick without any pick");

endmodule

/* sv/vpa_controller.sv */
// ----------------------------------------------------------------------------
// vpa_controller
// Sequencer for allocate and reclaim: scan, check, shift, merge and result.
// ----------------------------------------------------------------------------
module vpa_controller (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  vpa_pkg::stat_t stat_i,
  output vpa_pkg::ctrl_t ctrl_o
);
  import vpa_pkg::*;

  state_e     state_q, state_d;
  logic [2:0] fail_q, fail_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_INIT;
      fail_q  <= STATUS_OK;
    end else begin
      state_q <= state_d;
      fail_q  <= fail_d;
    end
  end

  always_comb begin
    state_d = state_q;
    fail_d  = fail_q;
    ctrl_o  = '{op: OP_NONE, status: fail_q};
    in_stall_o = (state_q != S_IDLE);
    case (state_q)
      S_INIT: begin
        ctrl_o.op = OP_INIT;
        state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid_i) begin
          ctrl_o.op = OP_LOAD;
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        ctrl_o.op = OP_SCAN;
        if (stat_i.scan_done) state_d = S_CHECK;
      end
      S_CHECK: begin
        if (stat_i.reclaim) begin
          if (!stat_i.found) begin
            fail_d = STATUS_NOOWNER; state_d = S_FAIL;
          end else begin
            state_d = S_RD_PREV;
          end
        end else if (stat_i.zero_size) begin
          fail_d = STATUS_ZERO; state_d = S_FAIL;
        end else if (!stat_i.found) begin
          fail_d = STATUS_NOFIT; state_d = S_FAIL;
        end else if (stat_i.split && stat_i.full) begin
          fail_d = STATUS_FULL; state_d = S_FAIL;
        end else if (stat_i.split) begin
          state_d = S_PREP_UP;
        end else begin
          state_d = S_GRANT;
        end
      end
      S_PREP_UP: begin
        ctrl_o.op = OP_PREP_UP;
        state_d = S_SHIFT_UP;
      end
      S_SHIFT_UP: begin
        ctrl_o.op = OP_SHIFT_UP;
        if (stat_i.up_done) state_d = S_SPLIT;
      end
      S_SPLIT: begin
        ctrl_o.op = OP_SPLIT;
        state_d = S_GRANT;
      end
      S_GRANT: begin
        if (stat_i.out_free) begin
          ctrl_o.op = OP_GRANT;
          state_d = S_IDLE;
        end
      end
      S_RD_PREV: begin
        ctrl_o.op = OP_RD_PREV;
        state_d = S_RD_NEXT;
      end
      S_RD_NEXT: begin
        ctrl_o.op = OP_RD_NEXT;
        state_d = S_CAP_NEXT;
      end
      S_CAP_NEXT: begin
        ctrl_o.op = OP_CAP_NEXT;
        state_d = S_PREP_DN;
      end
      S_PREP_DN: begin
        if (stat_i.merge_any) begin
          ctrl_o.op = OP_PREP_DN;
          state_d = S_SHIFT_DN;
        end else begin
          state_d = S_MERGE;
        end
      end
      S_SHIFT_DN: begin
        ctrl_o.op = OP_SHIFT_DN;
        if (stat_i.dn_done) state_d = S_MERGE;
      end
      S_MERGE: begin
        if (stat_i.out_free) begin
          ctrl_o.op = OP_MERGE;
          state_d = S_IDLE;
        end
      end
      S_FAIL: begin
        if (stat_i.out_free) begin
          ctrl_o.op = OP_FAIL;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

/* sv/variable_partition_allocator.sv */
// ----------------------------------------------------------------------------
// variable_partition_allocator
// Partition table allocator with first, next, best and worst fit placement.
// ----------------------------------------------------------------------------
// One item is worked at a time. An item's scan reads the table through its
// single read port, entry by entry over the partitions held; an allocation
// that splits an entry or a reclaim that merges neighbors then moves the
// entries behind it, and the table is written back; the result sits in an
// output register while the next item is taken. After reset the first table
// entry is written before the first item is taken.
// ----------------------------------------------------------------------------
module variable_partition_allocator #(
  parameter int unsigned POOL_UNITS = vpa_pkg::POOL_UNITS_DEF,
  parameter int unsigned MAX_PARTS  = vpa_pkg::MAX_PARTS_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  logic [1:0]    cfg_wdata_i,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  vpa_pkg::in_t  in_item_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output vpa_pkg::out_t out_item_o
);
  import vpa_pkg::*;

  ctrl_t ctrl;
  stat_t stat;

  vpa_controller u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .ctrl_o     (ctrl)
  );

  vpa_datapath #(
    .POOL_UNITS (POOL_UNITS),
    .MAX_PARTS  (MAX_PARTS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_item_i   (in_item_i),
    .ctrl_i      (ctrl),
    .stat_o      (stat),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_item_o  (out_item_o)
  );

endmodule

/* tb/sv/tb_variable_partition_allocator.sv */
// ----------------------------------------------------------------------------
// tb_variable_partition_allocator
// Self-checking bench for the variable partition allocator. A driver sends
// allocate and reclaim items from a queue under random idle, a monitor
// compares each result with a partition table kept in the bench, and the
// placement policy is changed between phases while the block is idle.
// ----------------------------------------------------------------------------
module tb_variable_partition_allocator;
  import vpa_pkg::*;

  localparam int unsigned POOL = POOL_UNITS_DEF;
  localparam int unsigned NPARTS = MAX_PARTS_DEF;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [1:0] cfg_wdata_i = FIT_FIRST;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  in_t in_item_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  out_t out_item_o;

  variable_partition_allocator uut (
    .clk_i(clk_i), .rst_ni(rst_ni), .cfg_we_i(cfg_we_i), .cfg_wdata_i(cfg_wdata_i),
    .in_valid_i(in_valid_i), .in_stall_o(in_stall_o), .in_item_i(in_item_i),
    .out_valid_o(out_valid_o), .out_stall_i(out_stall_i), .out_item_o(out_item_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // bench copy of the partition table
  logic [15:0] tbl_base [NPARTS];
  logic [15:0] tbl_len [NPARTS];
  logic tbl_used [NPARTS];
  logic [15:0] tbl_owner [NPARTS];
  logic [15:0] tbl_stamp [NPARTS];
  int tbl_count;
  logic [15:0] rover;
  logic [15:0] stamp_now;
  logic [1:0] policy;

  in_t pending_items[$];
  out_t expected_grants[$];
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int errors = 0;
  bit in_taken = 1'b0;

  function automatic void table_reset();
    for (int i = 0; i < NPARTS; i++) begin
      tbl_base[i] = '0;
      tbl_len[i] = '0;
      tbl_used[i] = 1'b0;
      tbl_owner[i] = '0;
      tbl_stamp[i] = '0;
    end
    tbl_len[0] = 16'(POOL);
    tbl_count = 1;
    rover = '0;
    stamp_now = '0;
    policy = FIT_FIRST;
  endfunction

  function automatic void move_entry(int dst, int src);
    tbl_base[dst] = tbl_base[src];
    tbl_len[dst] = tbl_len[src];
    tbl_used[dst] = tbl_used[src];
    tbl_owner[dst] = tbl_owner[src];
    tbl_stamp[dst] = tbl_stamp[src];
  endfunction

  function automatic void drop_entry(int idx);
    for (int k = idx; k + 1 < tbl_count; k++) move_entry(k, k + 1);
    tbl_count--;
  endfunction

  function automatic int pick_hole(logic [15:0] size);
    int pick;
    int start;
    int j;
    pick = -1;
    start = 0;
    if (policy == FIT_NEXT) begin
      for (int i = 0; i < tbl_count; i++)
        if (rover >= tbl_base[i] && 32'(rover) < 32'(tbl_base[i]) + 32'(tbl_len[i])) begin
          start = i;
          break;
        end
      for (int n = 0; n < tbl_count; n++) begin
        j = (start + n) % tbl_count;
        if (!tbl_used[j] && tbl_len[j] >= size) return j;
      end
      return -1;
    end
    for (int i = 0; i < tbl_count; i++) begin
      if (tbl_used[i] || tbl_len[i] < size) continue;
      if (policy == FIT_FIRST) return i;
      if (pick < 0 || (policy == FIT_BEST && tbl_len[i] < tbl_len[pick]) ||
          (policy == FIT_WORST && tbl_len[i] > tbl_len[pick]))
        pick = i;
    end
    return pick;
  endfunction

  function automatic out_t allocator_step(in_t it);
    out_t r;
    int i;
    int pick;
    logic [15:0] age;
    logic [15:0] best_age;
    logic [31:0] end_addr;
    r = '0;
    if (it.command == CMD_ALLOC) begin
      if (it.request_size == 0) begin
        r.status = STATUS_ZERO;
        return r;
      end
      i = pick_hole(it.request_size);
      if (i < 0) begin
        r.status = STATUS_NOFIT;
        return r;
      end
      if (tbl_len[i] > it.request_size) begin
        if (tbl_count >= NPARTS) begin
          r.status = STATUS_FULL;
          return r;
        end
        for (int k = tbl_count; k > i + 1; k--) move_entry(k, k - 1);
        tbl_base[i+1] = tbl_base[i] + it.request_size;
        tbl_len[i+1] = tbl_len[i] - it.request_size;
        tbl_used[i+1] = 1'b0;
        tbl_owner[i+1] = '0;
        tbl_stamp[i+1] = '0;
        tbl_count++;
        tbl_len[i] = it.request_size;
      end
      tbl_used[i] = 1'b1;
      tbl_owner[i] = it.owner_id;
      tbl_stamp[i] = stamp_now;
      stamp_now = stamp_now + 16'd1;
      end_addr = 32'(tbl_base[i]) + 32'(it.request_size);
      rover = (end_addr >= POOL) ? 16'd0 : end_addr[15:0];
      r.status = STATUS_OK;
      r.granted_base = tbl_base[i];
      r.granted_length = it.request_size;
      return r;
    end
    pick = -1;
    best_age = '0;
    for (int k = 0; k < tbl_count; k++) begin
      if (!tbl_used[k] || tbl_owner[k] != it.owner_id) continue;
      age = stamp_now - tbl_stamp[k];
      if (pick < 0 || age > best_age) begin
        pick = k;
        best_age = age;
      end
    end
    if (pick < 0) begin
      r.status = STATUS_NOOWNER;
      return r;
    end
    r.status = STATUS_OK;
    r.granted_base = tbl_base[pick];
    r.granted_length = tbl_len[pick];
    tbl_used[pick] = 1'b0;
    tbl_owner[pick] = '0;
    tbl_stamp[pick] = '0;
    if (pick > 0 && !tbl_used[pick-1]) begin
      tbl_len[pick-1] = tbl_len[pick-1] + tbl_len[pick];
      drop_entry(pick);
      pick--;
    end
    if (pick + 1 < tbl_count && !tbl_used[pick+1]) begin
      tbl_len[pick] = tbl_len[pick] + tbl_len[pick+1];
      drop_entry(pick + 1);
    end
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
    $display("mismatch %s: got %0d, expected %0d", what, got, want);
    errors++;
  endtask

  // driver
  always @(negedge clk_i) begin
    if (in_taken) begin
      void'(pending_items.pop_front());
    end
    if (in_valid_i && !in_taken) begin
      // hold the stalled item
    end else if (pending_items.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
      in_item_i <= pending_items[0];
      in_valid_i <= 1'b1;
    end else begin
      in_valid_i <= 1'b0;
    end
    out_stall_i <= ($urandom_range(99) < recv_idle_pct);
  end

  // predict at acceptance, check at result
  always @(posedge clk_i) begin
    in_taken <= rst_ni && in_valid_i && !in_stall_o;
    if (rst_ni && in_valid_i && !in_stall_o)
      expected_grants.insert(expected_grants.size(), allocator_step(in_item_i));
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_grants.size() == 0) begin
        report_mismatch("result with nothing expected", 16'(out_item_o.status), 16'd0);
      end else begin
        out_t want;
        want = expected_grants.pop_front();
        if (out_item_o.status != want.status)
          report_mismatch("status", 16'(out_item_o.status), 16'(want.status));
        if (out_item_o.granted_base != want.granted_base)
          report_mismatch("granted_base", out_item_o.granted_base, want.granted_base);
        if (out_item_o.granted_length != want.granted_length)
          report_mismatch("granted_length", out_item_o.granted_length,
                          want.granted_length);
      end
    end
  end

  task automatic drain();
    while (pending_items.size() > 0 || in_valid_i || expected_grants.size() > 0)
      @(posedge clk_i);
    repeat (80) @(posedge clk_i);
  endtask

  task automatic set_policy(logic [1:0] p);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= p;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    policy = p;
  endtask

  function automatic in_t make_item(logic cmd, logic [15:0] owner, logic [15:0] size);
    in_t it;
    it.command = cmd;
    it.owner_id = owner;
    it.request_size = size;
    return it;
  endfunction

  function automatic void queue_item(logic cmd, logic [15:0] owner, logic [15:0] size);
    pending_items.insert(pending_items.size(), make_item(cmd, owner, size));
  endfunction

  task automatic random_phase(int count);
    for (int n = 0; n < count; n++) begin
      int r;
      logic [15:0] sz;
      r = $urandom_range(99);
      if (r < 3) sz = 16'($urandom());
      else if (r < 6) sz = 16'd0;
      else if (r < 10) sz = 16'($urandom_range(POOL - 50, POOL + 10));
      else sz = 16'($urandom_range(1, 120));
      if ($urandom_range(99) < 4)
        queue_item(1'($urandom()), 16'($urandom()), sz);
      else
        queue_item(1'($urandom_range(99) < 42), 16'($urandom_range(0, 7)) ^ 16'hA5F0, sz);
    end
    drain();
  endtask

  initial begin
    table_reset();
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    repeat (4) @(negedge clk_i);
    // directed
    queue_item(CMD_ALLOC, 16'h0001, 16'd0);
    queue_item(CMD_RECLAIM, 16'hFFFF, 16'hFFFF);
    queue_item(CMD_ALLOC, 16'hFFFF, 16'hFFFF);
    queue_item(CMD_ALLOC, 16'h0001, 16'd100);
    queue_item(CMD_ALLOC, 16'h0002, 16'd50);
    queue_item(CMD_ALLOC, 16'h0001, 16'd200);
    queue_item(CMD_ALLOC, 16'h0003, 16'd50);
    queue_item(CMD_RECLAIM, 16'h0001, 16'd0);
    queue_item(CMD_RECLAIM, 16'h0003, 16'hFFFF);
    queue_item(CMD_RECLAIM, 16'h0002, 16'd0);
    queue_item(CMD_ALLOC, 16'h0000, 16'd600);
    queue_item(CMD_ALLOC, 16'h0004, 16'd400);
    queue_item(CMD_RECLAIM, 16'h0001, 16'd0);
    queue_item(CMD_RECLAIM, 16'h0000, 16'd0);
    queue_item(CMD_RECLAIM, 16'h0004, 16'd0);
    for (int k = 0; k < 33; k++)
      queue_item(CMD_ALLOC, 16'h0010, 16'd1);
    for (int k = 0; k < 33; k++)
      queue_item(CMD_RECLAIM, 16'h0010, 16'd0);
    drain();
    send_idle_pct = 31;
    recv_idle_pct = 50;
    set_policy(FIT_NEXT);
    random_phase(200);
    set_policy(FIT_BEST);
    random_phase(200);
    send_idle_pct = 50;
    recv_idle_pct = 31;
    set_policy(FIT_WORST);
    random_phase(200);
    set_policy(FIT_FIRST);
    random_phase(200);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    set_policy(FIT_NEXT);
    random_phase(200);
    set_policy(FIT_WORST);
    random_phase(200);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #20000000;
    $display("Verification failed");
    $finish;
  end

endmodule

/* files.f */
sv/vpa_pkg.sv
sv/vpa_datapath.sv
sv/vpa_controller.sv
sv/variable_partition_allocator.sv
tb/sv/tb_variable_partition_allocator.sv
